FILE: sv/lbpwh_pkg.sv
// Shared types and constants for the uniform LBP window histogram unit.
// Holds the word layouts, the controller state type and the command/status
// structs used between the controller and the datapath. No dependencies.
package lbpwh_pkg;

  // Input word layout: center sample, then the eight circle samples
  localparam int SAMPLE_W        = 16;
  localparam int FIELD_NEIGHBORS = 8;
  localparam int IN_DATA_W       = SAMPLE_W * (FIELD_NEIGHBORS + 1);

  // Output word layout: bin index, count, fraction, total, one pad bit
  localparam int BIN_IDX_W  = 4;
  localparam int OUT_FIELD_W = 17;
  localparam int OUT_DATA_W = 56;

  // Q0.16 fraction has 17 quotient bits (a full bin gives 1.0)
  localparam int QUO_W = 17;

  // Patterns with this many circular transitions or more are non-uniform
  localparam int TRANSITION_LIMIT = 3;

  typedef enum logic [2:0] {
    S_COUNT,
    S_SETTLE,
    S_LOAD,
    S_DIV,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic out_load;
    logic bin_next;
    logic hist_clear;
  } lbpwh_cmd_t;

  typedef struct packed {
    logic div_done;
    logic bin_last;
  } lbpwh_status_t;

endpackage

FILE: sv/lbpwh_divider.sv
// Restoring divider for the Q0.16 bin fraction, one quotient bit a cycle.
// Computes floor(dividend * 65536 / divisor) for dividend <= divisor.
// Uses lbpwh_pkg for the quotient width.
module lbpwh_divider #(
  parameter int CNT_W = 17
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [CNT_W-1:0]               dividend_i,
  input  logic [CNT_W-1:0]               divisor_i,
  output logic                           done_o,
  output logic [lbpwh_pkg::QUO_W-1:0]    quotient_o
);

  localparam int STEP_W = $clog2(lbpwh_pkg::QUO_W);

  logic [CNT_W:0]                  rem_q, rem_d;
  logic [CNT_W-1:0]                div_q;
  logic [lbpwh_pkg::QUO_W-1:0]     quo_q, quo_d;
  logic [STEP_W-1:0]               step_q, step_d;
  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [CNT_W:0]                  trial;
  logic                            fits;

  // First step compares the count itself, later steps shift the remainder in
  always_comb begin
    trial = (step_q == '0) ? rem_q : {rem_q[CNT_W-1:0], 1'b0};
    fits  = trial >= {1'b0, div_q};
  end

  // Advance one quotient bit per cycle while busy
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = {1'b0, dividend_i};
      quo_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d  = fits ? (trial - {1'b0, div_q}) : trial;
      quo_d  = {quo_q[lbpwh_pkg::QUO_W-2:0], fits};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(lbpwh_pkg::QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Hold the operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: sv/lbpwh_datapath.sv
// Datapath: pattern coder, code stage, bin counters, pixel total, drain
// index, fraction divider and the output word register.
// Uses lbpwh_pkg and instantiates lbpwh_divider.
module lbpwh_datapath #(
  parameter int NEIGHBORS = 8,
  parameter int MAX_WINDOW_PIXELS = 65536,
  parameter int NUM_BINS = 10,
  parameter int IDX_W = 4,
  parameter int CNT_W = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lbpwh_pkg::lbpwh_cmd_t             cmd_i,
  output lbpwh_pkg::lbpwh_status_t          status_o,
  input  logic [lbpwh_pkg::IN_DATA_W-1:0]   in_data_i,
  output logic [lbpwh_pkg::OUT_DATA_W-1:0]  out_data_o,
  output logic                              out_last_o
);

  localparam int ONES_W = $clog2(NEIGHBORS + 1);
  localparam int EXT_W  = CNT_W + lbpwh_pkg::OUT_FIELD_W;

  logic [lbpwh_pkg::SAMPLE_W-1:0] center;
  logic [lbpwh_pkg::SAMPLE_W-1:0] circ [NEIGHBORS];
  logic [NEIGHBORS-1:0]           pat;
  logic [NEIGHBORS-1:0]           rot;
  logic [ONES_W-1:0]              ones;
  logic [ONES_W-1:0]              trans;
  logic [IDX_W-1:0]               code;

  logic                           stage_valid_q;
  logic [IDX_W-1:0]               code_q;
  logic [CNT_W-1:0]               bins_q [NUM_BINS];
  logic [CNT_W-1:0]               pixels_q;
  logic                           full;
  logic                           count_en;
  logic [IDX_W-1:0]               bin_idx_q;

  logic                           div_done;
  logic [lbpwh_pkg::QUO_W-1:0]    quotient;
  logic [CNT_W-1:0]               bin_sel;
  logic [EXT_W-1:0]               count_ext;
  logic [EXT_W-1:0]               total_ext;

  logic [lbpwh_pkg::BIN_IDX_W-1:0]   out_idx_q;
  logic [lbpwh_pkg::OUT_FIELD_W-1:0] out_count_q;
  logic [lbpwh_pkg::OUT_FIELD_W-1:0] out_frac_q;
  logic [lbpwh_pkg::OUT_FIELD_W-1:0] out_total_q;
  logic                              out_last_q;

  assign center = in_data_i[lbpwh_pkg::SAMPLE_W-1:0];

  // Circle positions beyond the word's eight samples read as zero
  for (genvar p = 0; p < NEIGHBORS; p++) begin : g_circ
    if (p < lbpwh_pkg::FIELD_NEIGHBORS) begin : g_field
      assign circ[p] = in_data_i[(p+1)*lbpwh_pkg::SAMPLE_W +: lbpwh_pkg::SAMPLE_W];
    end else begin : g_zero
      assign circ[p] = '0;
    end
  end

  // Threshold against the center; neighbor 0 is the top pattern bit
  always_comb begin
    for (int p = 0; p < NEIGHBORS; p++) begin
      pat[NEIGHBORS-1-p] = circ[p] >= center;
    end
  end

  assign rot = {pat[NEIGHBORS-2:0], pat[NEIGHBORS-1]};

  // Count ones and circular transitions, map to the uniform code
  always_comb begin
    ones  = '0;
    trans = '0;
    for (int p = 0; p < NEIGHBORS; p++) begin
      ones  = ones + ONES_W'(pat[p]);
      trans = trans + ONES_W'(pat[p] ^ rot[p]);
    end
    if (trans >= ONES_W'(lbpwh_pkg::TRANSITION_LIMIT)) begin
      code = '0;
    end else begin
      code = IDX_W'(ones) + IDX_W'(1);
    end
  end

  // Register the code of each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= cmd_i.accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      code_q <= code;
    end
  end

  // Count pixels until the window is full
  assign full     = pixels_q == CNT_W'(MAX_WINDOW_PIXELS);
  assign count_en = stage_valid_q && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_q <= '0;
      for (int k = 0; k < NUM_BINS; k++) begin
        bins_q[k] <= '0;
      end
    end else if (cmd_i.hist_clear) begin
      pixels_q <= '0;
      for (int k = 0; k < NUM_BINS; k++) begin
        bins_q[k] <= '0;
      end
    end else if (count_en) begin
      pixels_q <= pixels_q + CNT_W'(1);
      for (int k = 0; k < NUM_BINS; k++) begin
        if (code_q == IDX_W'(k)) begin
          bins_q[k] <= bins_q[k] + CNT_W'(1);
        end
      end
    end
  end

  // Step through the bins during the drain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_idx_q <= '0;
    end else if (cmd_i.hist_clear) begin
      bin_idx_q <= '0;
    end else if (cmd_i.bin_next) begin
      bin_idx_q <= bin_idx_q + IDX_W'(1);
    end
  end

  assign bin_sel = bins_q[bin_idx_q];

  lbpwh_divider #(
    .CNT_W (CNT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (bin_sel),
    .divisor_i  (pixels_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Output fields carry the low 17 bits of count and total
  assign count_ext = {{lbpwh_pkg::OUT_FIELD_W{1'b0}}, bin_sel};
  assign total_ext = {{lbpwh_pkg::OUT_FIELD_W{1'b0}}, pixels_q};

  // Capture one result word when the quotient is ready
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q   <= lbpwh_pkg::BIN_IDX_W'(bin_idx_q);
      out_count_q <= count_ext[lbpwh_pkg::OUT_FIELD_W-1:0];
      out_frac_q  <= quotient;
      out_total_q <= total_ext[lbpwh_pkg::OUT_FIELD_W-1:0];
      out_last_q  <= bin_idx_q == IDX_W'(NUM_BINS - 1);
    end
  end

  assign out_data_o = {1'b0, out_total_q, out_frac_q, out_count_q, out_idx_q};
  assign out_last_o = out_last_q;

  assign status_o.div_done = div_done;
  assign status_o.bin_last = bin_idx_q == IDX_W'(NUM_BINS - 1);

endmodule

FILE: sv/lbpwh_ctrl.sv
// Controller: accepts pixel words, then sequences the bin drain through the
// divider and the output register. Uses lbpwh_pkg for state and command types.
module lbpwh_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_last_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  lbpwh_pkg::lbpwh_status_t  status_i,
  output lbpwh_pkg::lbpwh_cmd_t     cmd_o
);

  lbpwh_pkg::ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lbpwh_pkg::S_COUNT: begin
        if (in_valid_i && in_last_i) begin
          state_d = lbpwh_pkg::S_SETTLE;
        end
      end
      lbpwh_pkg::S_SETTLE: begin
        state_d = lbpwh_pkg::S_LOAD;
      end
      lbpwh_pkg::S_LOAD: begin
        state_d = lbpwh_pkg::S_DIV;
      end
      lbpwh_pkg::S_DIV: begin
        if (status_i.div_done) begin
          state_d = lbpwh_pkg::S_EMIT;
        end
      end
      lbpwh_pkg::S_EMIT: begin
        if (out_ready_i) begin
          state_d = status_i.bin_last ? lbpwh_pkg::S_COUNT : lbpwh_pkg::S_LOAD;
        end
      end
      default: begin
        state_d = lbpwh_pkg::S_COUNT;
      end
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      lbpwh_pkg::S_COUNT: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      lbpwh_pkg::S_LOAD: begin
        cmd_o.div_start = 1'b1;
      end
      lbpwh_pkg::S_DIV: begin
        cmd_o.out_load = status_i.div_done;
      end
      lbpwh_pkg::S_EMIT: begin
        out_valid_o      = 1'b1;
        cmd_o.hist_clear = out_ready_i && status_i.bin_last;
        cmd_o.bin_next   = out_ready_i && !status_i.bin_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbpwh_pkg::S_COUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/uniform_lbp_window_histogram_unit.sv
// Uniform local binary pattern histogram over a window of pixels.
// Top level: joins lbpwh_ctrl and lbpwh_datapath; uses lbpwh_pkg.
//
// Usage:
//   Slave channel: one word per pixel, center sample and the circle samples;
//   tlast marks the window's final pixel. Each pixel's code is registered and
//   counted in the next cycle; one pixel is taken per cycle outside the drain.
//   Once the window holds MAX_WINDOW_PIXELS pixels, further pixels are dropped
//   from the count, but a last pixel still starts the drain.
//   Master channel: after the last pixel, NEIGHBORS+2 words, one per bin in
//   bin order, each with count, Q0.16 fraction of the total and the total;
//   tlast marks the final bin. Then the histogram is cleared.
//   Drain: after the last pixel is accepted the controller settles, then for
//   each bin starts the 17-step bit-serial fraction divider, loads the word
//   when it is done and offers it until the receiver takes it. No pixel is
//   taken while the drain runs.
//   Stall: a bin word holds on the master channel until taken.
//   Reset: clears counts, total and controller; the block starts idle and ready.
module uniform_lbp_window_histogram_unit #(
  parameter int NEIGHBORS = 8,
  parameter int MAX_WINDOW_PIXELS = 65536
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: center_sample[15:0], neighbor_0[31:16] .. neighbor_7[143:128]
  input  logic [lbpwh_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: bin_index[3:0], bin_count[20:4], bin_fraction[37:21],
  //        pixel_total[54:38], zero pad[55]
  output logic [lbpwh_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i
);

  localparam int NUM_BINS = NEIGHBORS + 2;
  localparam int IDX_W    = $clog2(NUM_BINS);
  localparam int CNT_W    = $clog2(MAX_WINDOW_PIXELS + 1);

  lbpwh_pkg::lbpwh_cmd_t    cmd;
  lbpwh_pkg::lbpwh_status_t status;

  lbpwh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lbpwh_datapath #(
    .NEIGHBORS         (NEIGHBORS),
    .MAX_WINDOW_PIXELS (MAX_WINDOW_PIXELS),
    .NUM_BINS          (NUM_BINS),
    .IDX_W             (IDX_W),
    .CNT_W             (CNT_W)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

  // No pixel is taken while a bin word is on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("pixel channel ready during drain");

  // Taking the final bin returns the block to counting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> s_axis_tready_o)
    else $error("block did not resume after final bin");

  // A fraction never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[37:21] <= 17'h10000)
    else $error("bin fraction above one");

  // Accepting a last pixel starts the drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && s_axis_tvalid_i && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("pixel accepted right after window end");

endmodule
